>>> rtl/core/rect_fill_window_command_gen_core_macros.svh
// Assertion helpers for the rectangle fill core, used by its sequencer (rfwc_back).
`ifndef RECT_FILL_WINDOW_COMMAND_GEN_CORE_MACROS_SVH
`define RECT_FILL_WINDOW_COMMAND_GEN_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RFWC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);
`define RFWC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);
`else
`define RFWC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFWC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> rtl/core/rfwc_pkg.sv
package rfwc_pkg;

    typedef struct packed {
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
        logic        [15:0] fill_color;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [15:0] burst_color;
        logic [15:0] burst_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] rotation;
        logic [7:0] panel_width;
        logic [7:0] panel_height;
    } t_cfg;

    // One clipped request, ready for the sequencer.
    typedef struct packed {
        logic [5:0][7:0] win;
        logic [15:0]     color;
        logic [15:0]     count;
    } t_job;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_BURST = 2'd2;

    localparam logic [7:0] CMD_COL_WINDOW = 8'h44;
    localparam logic [7:0] CMD_ROW_WINDOW = 8'h45;
    localparam logic [7:0] CMD_RAM_ADDR   = 8'h21;
    localparam logic [7:0] CMD_RAM_WRITE  = 8'h22;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] REG_ROTATION     = 2'd0;
    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd1;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd2;

    localparam logic [1:0] RST_ROTATION = 2'd2;
    localparam logic [7:0] RST_PANEL    = 8'd130;

    localparam int QUEUE_DEPTH = 2;
    localparam int SEQ_LEN     = 12;

endpackage

>>> rtl/core/rfwc_front.sv
module rfwc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rfwc_pkg::t_in_item  i_item,
    output logic                o_full,
    input  rfwc_pkg::t_cfg      i_cfg,
    output logic                o_job_valid,
    output rfwc_pkg::t_job      o_job,
    input  logic                i_job_full
);

    // Clip one axis: pos is already non-negative, len may be anything.
    function automatic logic signed [17:0] clip_len(input logic [14:0] pos,
                                                    input logic signed [16:0] len,
                                                    input logic [7:0] lim);
        logic signed [17:0] ext_len;
        logic signed [17:0] sum;
        logic signed [17:0] room;
        logic signed [17:0] lim_s;
        ext_len  = {len[16], len};
        lim_s    = $signed({10'd0, lim});
        sum      = $signed({3'b000, pos}) + ext_len;
        room     = lim_s - $signed({3'b000, pos});
        clip_len = (sum > lim_s) ? room : ext_len;
    endfunction

    // Stage 1: fold negative origin into the length.
    logic               r_s1_v;
    logic [14:0]        r_s1_x;
    logic [14:0]        r_s1_y;
    logic signed [16:0] r_s1_w;
    logic signed [16:0] r_s1_h;
    logic [15:0]        r_s1_color;

    // Stage 2: clipped rectangle, always non-empty when valid.
    logic               r_s2_v;
    logic [7:0]         r_s2_x;
    logic [7:0]         r_s2_y;
    logic [7:0]         r_s2_w;
    logic [7:0]         r_s2_h;
    logic [15:0]        r_s2_color;

    logic               en1;
    logic               en2;
    logic signed [16:0] n_s1_w;
    logic signed [16:0] n_s1_h;
    logic [7:0]         vis_w;
    logic [7:0]         vis_h;
    logic signed [17:0] clip_w;
    logic signed [17:0] clip_h;
    logic               non_empty;
    logic [7:0]         x1;
    logic [7:0]         x2;
    logic [7:0]         y1;
    logic [7:0]         y2;
    logic [7:0]         pw;
    logic [7:0]         ph;

    assign en2    = !r_s2_v || !i_job_full;
    assign en1    = !r_s1_v || en2;
    assign o_full = !en1;

    assign n_s1_w = i_item.rect_x[15]
                  ? ({i_item.rect_w[15], i_item.rect_w} + {i_item.rect_x[15], i_item.rect_x})
                  : {i_item.rect_w[15], i_item.rect_w};
    assign n_s1_h = i_item.rect_y[15]
                  ? ({i_item.rect_h[15], i_item.rect_h} + {i_item.rect_y[15], i_item.rect_y})
                  : {i_item.rect_h[15], i_item.rect_h};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en1) begin
            r_s1_v <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_x     <= i_item.rect_x[15] ? 15'd0 : i_item.rect_x[14:0];
            r_s1_y     <= i_item.rect_y[15] ? 15'd0 : i_item.rect_y[14:0];
            r_s1_w     <= n_s1_w;
            r_s1_h     <= n_s1_h;
            r_s1_color <= i_item.fill_color;
        end
    end

    // Odd rotation swaps the visible bounds.
    assign vis_w = i_cfg.rotation[0] ? i_cfg.panel_height : i_cfg.panel_width;
    assign vis_h = i_cfg.rotation[0] ? i_cfg.panel_width  : i_cfg.panel_height;

    assign clip_w    = clip_len(r_s1_x, r_s1_w, vis_w);
    assign clip_h    = clip_len(r_s1_y, r_s1_h, vis_h);
    assign non_empty = !clip_w[17] && (clip_w != 18'sd0) && !clip_h[17] && (clip_h != 18'sd0);

    // Drop empty requests here so they never reach the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en2) begin
            r_s2_v <= r_s1_v && non_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_x     <= r_s1_x[7:0];
            r_s2_y     <= r_s1_y[7:0];
            r_s2_w     <= clip_w[7:0];
            r_s2_h     <= clip_h[7:0];
            r_s2_color <= r_s1_color;
        end
    end

    // Window bytes wrap at 8 bits.
    assign x1 = r_s2_x;
    assign y1 = r_s2_y;
    assign x2 = r_s2_x + r_s2_w - 8'd1;
    assign y2 = r_s2_y + r_s2_h - 8'd1;
    assign pw = i_cfg.panel_width;
    assign ph = i_cfg.panel_height;

    always_comb begin
        o_job.color = r_s2_color;
        o_job.count = {8'd0, r_s2_w} * {8'd0, r_s2_h};
        unique case (i_cfg.rotation)
            rfwc_pkg::ROT_0: begin
                o_job.win[0] = x2 + 8'd2;
                o_job.win[1] = x1 + 8'd2;
                o_job.win[2] = y2 + 8'd2;
                o_job.win[3] = y1 + 8'd2;
                o_job.win[4] = y1 + 8'd2;
                o_job.win[5] = x1 + 8'd2;
            end
            rfwc_pkg::ROT_90: begin
                o_job.win[0] = ph - y1 + 8'd1;
                o_job.win[1] = ph - y2 + 8'd1;
                o_job.win[2] = pw - x1 - 8'd1;
                o_job.win[3] = pw - x2 - 8'd1;
                o_job.win[4] = pw - x1 - 8'd1;
                o_job.win[5] = ph - y1 + 8'd1;
            end
            rfwc_pkg::ROT_180: begin
                o_job.win[0] = pw - x1 + 8'd1;
                o_job.win[1] = pw - x2 + 8'd1;
                o_job.win[2] = ph - y1 + 8'd1;
                o_job.win[3] = ph - y2 + 8'd1;
                o_job.win[4] = ph - y1 + 8'd1;
                o_job.win[5] = pw - x1 + 8'd1;
            end
            rfwc_pkg::ROT_270: begin
                o_job.win[0] = y2 + 8'd2;
                o_job.win[1] = y1 + 8'd2;
                o_job.win[2] = x2;
                o_job.win[3] = x1;
                o_job.win[4] = x1;
                o_job.win[5] = y1 + 8'd2;
            end
            default: begin
                o_job.win = '0;
            end
        endcase
    end

    assign o_job_valid = r_s2_v;

endmodule

>>> rtl/core/rfwc_queue.sv
module rfwc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rfwc_pkg::t_job  i_data,
    output logic            o_full,
    output logic            o_empty,
    output rfwc_pkg::t_job  o_head,
    input  logic            i_pop
);

    localparam int PTR_W = $clog2(rfwc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rfwc_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rfwc_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rfwc_pkg::QUEUE_DEPTH - 1);

    rfwc_pkg::t_job   r_mem [rfwc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/rfwc_back.sv
`include "rect_fill_window_command_gen_core_macros.svh"

module rfwc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_empty,
    input  rfwc_pkg::t_job      i_job,
    output logic                o_job_pop,
    output rfwc_pkg::t_out_item o_item,
    output logic                o_empty,
    input  logic                i_pop
);

    localparam int STEP_W = $clog2(rfwc_pkg::SEQ_LEN);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(rfwc_pkg::SEQ_LEN - 1);

    rfwc_pkg::t_job      r_job;
    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_v;
    rfwc_pkg::t_out_item r_out;
    rfwc_pkg::t_out_item n_item;
    logic                load_out;
    logic                emit;
    logic                fetch;

    assign load_out  = !r_out_v || i_pop;
    assign emit      = r_busy && load_out;
    // Take the next job as the current one hands over its final beat.
    assign fetch     = !i_job_empty && (!r_busy || (emit && r_step == STEP_LAST));
    assign o_job_pop = fetch;

    always_comb begin
        n_item = '0;
        unique case (r_step)
            STEP_W'(0): begin
                n_item.kind       = rfwc_pkg::KIND_CMD;
                n_item.byte_value = rfwc_pkg::CMD_COL_WINDOW;
            end
            STEP_W'(1), STEP_W'(2): begin
                n_item.kind       = rfwc_pkg::KIND_DATA;
                n_item.byte_value = r_step[0] ? r_job.win[0] : r_job.win[1];
            end
            STEP_W'(3): begin
                n_item.kind       = rfwc_pkg::KIND_CMD;
                n_item.byte_value = rfwc_pkg::CMD_ROW_WINDOW;
            end
            STEP_W'(4), STEP_W'(5): begin
                n_item.kind       = rfwc_pkg::KIND_DATA;
                n_item.byte_value = r_step[0] ? r_job.win[3] : r_job.win[2];
            end
            STEP_W'(6): begin
                n_item.kind       = rfwc_pkg::KIND_CMD;
                n_item.byte_value = rfwc_pkg::CMD_RAM_ADDR;
            end
            STEP_W'(7), STEP_W'(8): begin
                n_item.kind       = rfwc_pkg::KIND_DATA;
                n_item.byte_value = r_step[0] ? r_job.win[4] : r_job.win[5];
            end
            STEP_W'(9), STEP_W'(10): begin
                n_item.kind       = rfwc_pkg::KIND_CMD;
                n_item.byte_value = rfwc_pkg::CMD_RAM_WRITE;
            end
            STEP_W'(11): begin
                n_item.kind        = rfwc_pkg::KIND_BURST;
                n_item.burst_color = r_job.color;
                n_item.burst_count = r_job.count;
                n_item.last        = 1'b1;
            end
            default: begin
                n_item = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (fetch) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (emit) begin
            if (r_step == STEP_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (load_out) begin
            r_out_v <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_item;
        end
    end

    assign o_item  = r_out;
    assign o_empty = !r_out_v;

    `RFWC_ASSERT(a_step_in_range, i_clk, i_rst_n, r_busy |-> (r_step <= STEP_LAST), "sequencer step out of range")
    `RFWC_ASSERT(a_fetch_when_free, i_clk, i_rst_n, fetch |-> (!r_busy || (emit && r_step == STEP_LAST)), "job fetched while sequence in flight")
    `RFWC_ASSERT(a_new_job_from_start, i_clk, i_rst_n, $past(fetch) |-> (r_busy && r_step == '0), "new job did not start at the first command")
    `RFWC_ASSERT(a_last_only_on_burst, i_clk, i_rst_n, (r_out_v && r_out.last) |-> (r_out.kind == rfwc_pkg::KIND_BURST), "last flag on a non-burst beat")
    `RFWC_ASSERT_NEVER(a_no_pop_when_empty, i_clk, i_rst_n, o_job_pop && i_job_empty, "job queue popped while empty")

endmodule

>>> rtl/core/rect_fill_window_command_gen_core.sv
// Rectangle fill command generator.
// Input channel: push/full with one fill request per beat (rect_x, rect_y,
// rect_w, rect_h, fill_color). Result channel: empty/pop, one controller
// beat at a time: command 0x44 and two window bytes, 0x45 and two bytes,
// 0x21 and two bytes, two 0x22 commands, then the pixel burst with last set.
// A request whose clipped rectangle is empty produces no beats at all.
// A request passes stage 1, stage 2, the job queue and the sequencer, and its
// first beat is registered in the output stage before it shows on the ports.
// Throughput: twelve beats per request, one beat per cycle while pop is high;
// the sequencer takes the next job as it hands over the last beat of the
// current one. Two clip stages and a two-entry job queue sit in front of it,
// so up to four requests are absorbed while the result side stalls; full rises
// once they are all taken, and beats are held while pop is low.
// Configuration (APB byte offsets 0x0 rotation, 0x4 panel_width, 0x8
// panel_height) must be changed only while the block is idle (not enforced).
// Reset: synchronous, active low; empties all stages and the queue and loads
// rotation 2 and a 130 by 130 panel.
module rect_fill_window_command_gen_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  rfwc_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output rfwc_pkg::t_out_item o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    rfwc_pkg::t_cfg r_cfg;
    logic           cfg_wr;
    logic [1:0]     reg_idx;
    logic           job_valid;
    rfwc_pkg::t_job job_in;
    logic           job_full;
    logic           job_empty;
    rfwc_pkg::t_job job_head;
    logic           job_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation     <= rfwc_pkg::RST_ROTATION;
            r_cfg.panel_width  <= rfwc_pkg::RST_PANEL;
            r_cfg.panel_height <= rfwc_pkg::RST_PANEL;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rfwc_pkg::REG_ROTATION:     r_cfg.rotation     <= pwdata[1:0];
                rfwc_pkg::REG_PANEL_WIDTH:  r_cfg.panel_width  <= pwdata[7:0];
                rfwc_pkg::REG_PANEL_HEIGHT: r_cfg.panel_height <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rfwc_pkg::REG_ROTATION:     prdata = {30'd0, r_cfg.rotation};
            rfwc_pkg::REG_PANEL_WIDTH:  prdata = {24'd0, r_cfg.panel_width};
            rfwc_pkg::REG_PANEL_HEIGHT: prdata = {24'd0, r_cfg.panel_height};
            default:                    prdata = '0;
        endcase
    end

    rfwc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cfg       (r_cfg),
        .o_job_valid (job_valid),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    rfwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (job_full),
        .o_empty (job_empty),
        .o_head  (job_head),
        .i_pop   (job_pop)
    );

    rfwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .o_item      (o_item),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
